FILE: src/fdi_pkg.sv
// Package for the printf integer-to-ASCII conversion core.
// Holds micro-op, condition and control word types, ASCII codes and sizes.
// No dependencies; used by every module of the core.
package fdi_pkg;

  localparam int FUNC_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 4;
  localparam int STEP_W   = 5;
  localparam int NDIG     = 11;               // digit slots, one nibble each
  localparam int DIG_W    = NDIG * 4;
  localparam int CNT_W    = 5;                // double-dabble iteration counter
  localparam int S_DATA_W = 40;               // func + value
  localparam int M_DATA_W = 16;               // char + count, byte padded

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] LTR_D    = 8'h64;
  localparam logic [7:0] LTR_U    = 8'h75;
  localparam logic [7:0] LTR_O    = 8'h6F;
  localparam logic [7:0] LTR_X    = 8'h78;
  localparam logic [7:0] LTR_C    = 8'h63;

  // Datapath micro-ops
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT_DEC,
    OP_DABBLE,
    OP_LOAD_DEC,
    OP_INIT_OCT,
    OP_INIT_HEX,
    OP_SKIP,
    OP_EMIT
  } op_t;

  // Character source for an emit step
  typedef enum logic [2:0] {
    SRC_DIGIT,
    SRC_MINUS,
    SRC_PCT,
    SRC_FUNC,
    SRC_BYTE
  } src_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_F_DEC,
    C_F_OCT,
    C_F_HEX,
    C_F_CHR,
    C_F_PCT,
    C_CNT_NZ,
    C_LEADZ,
    C_NOT_NEG,
    C_MORE
  } cond_t;

  // Microcode word
  typedef struct packed {
    op_t                op;
    src_t               src;
    logic               last;
    logic               wait_in;
    cond_t              cond;
    logic [STEP_W-1:0]  target;
  } ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic f_dec;
    logic f_oct;
    logic f_hex;
    logic f_chr;
    logic f_pct;
    logic cnt_nz;
    logic leadz;
    logic neg;
    logic more;
  } status_t;

  // Program addresses
  localparam logic [STEP_W-1:0] ST_WAIT     = 5'd0;
  localparam logic [STEP_W-1:0] ST_OTHER    = 5'd6;
  localparam logic [STEP_W-1:0] ST_PCT      = 5'd8;
  localparam logic [STEP_W-1:0] ST_CHR      = 5'd9;
  localparam logic [STEP_W-1:0] ST_DEC      = 5'd10;
  localparam logic [STEP_W-1:0] ST_DABBLE   = 5'd11;
  localparam logic [STEP_W-1:0] ST_OCT      = 5'd13;
  localparam logic [STEP_W-1:0] ST_HEX      = 5'd14;
  localparam logic [STEP_W-1:0] ST_SKIP     = 5'd15;
  localparam logic [STEP_W-1:0] ST_DIGITS   = 5'd18;

  // Character for one digit value, radix up to 16
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end else begin
      return CH_A + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

FILE: src/fdi_urom.sv
// Microcode ROM of the conversion core: one control word per step.
// Depends on fdi_pkg for the control word layout and step addresses.
module fdi_urom (
  input  logic [fdi_pkg::STEP_W-1:0] addr,
  output fdi_pkg::ctrl_t             ctrl
);
  import fdi_pkg::*;

  // Decode the step address into its control word
  always_comb begin
    ctrl = '{op: OP_NONE, src: SRC_DIGIT, last: 1'b0, wait_in: 1'b0,
             cond: C_ALWAYS, target: ST_WAIT};
    case (addr)
      5'd0: begin
        ctrl.wait_in = 1'b1;
        ctrl.cond    = C_NO_IN;
        ctrl.target  = ST_WAIT;
      end
      5'd1: begin
        ctrl.cond = C_F_DEC;  ctrl.target = ST_DEC;
      end
      5'd2: begin
        ctrl.cond = C_F_OCT;  ctrl.target = ST_OCT;
      end
      5'd3: begin
        ctrl.cond = C_F_HEX;  ctrl.target = ST_HEX;
      end
      5'd4: begin
        ctrl.cond = C_F_CHR;  ctrl.target = ST_CHR;
      end
      5'd5: begin
        ctrl.cond = C_F_PCT;  ctrl.target = ST_PCT;
      end
      5'd6: begin
        ctrl.op = OP_EMIT;  ctrl.src = SRC_PCT;  ctrl.cond = C_NEVER;
      end
      5'd7: begin
        ctrl.op = OP_EMIT;  ctrl.src = SRC_FUNC;  ctrl.last = 1'b1;
      end
      5'd8: begin
        ctrl.op = OP_EMIT;  ctrl.src = SRC_PCT;  ctrl.last = 1'b1;
      end
      5'd9: begin
        ctrl.op = OP_EMIT;  ctrl.src = SRC_BYTE;  ctrl.last = 1'b1;
      end
      5'd10: begin
        ctrl.op = OP_INIT_DEC;  ctrl.cond = C_NEVER;
      end
      5'd11: begin
        ctrl.op = OP_DABBLE;  ctrl.cond = C_CNT_NZ;  ctrl.target = ST_DABBLE;
      end
      5'd12: begin
        ctrl.op = OP_LOAD_DEC;  ctrl.target = ST_SKIP;
      end
      5'd13: begin
        ctrl.op = OP_INIT_OCT;  ctrl.target = ST_SKIP;
      end
      5'd14: begin
        ctrl.op = OP_INIT_HEX;  ctrl.cond = C_NEVER;
      end
      5'd15: begin
        ctrl.op = OP_SKIP;  ctrl.cond = C_LEADZ;  ctrl.target = ST_SKIP;
      end
      5'd16: begin
        ctrl.cond = C_NOT_NEG;  ctrl.target = ST_DIGITS;
      end
      5'd17: begin
        ctrl.op = OP_EMIT;  ctrl.src = SRC_MINUS;  ctrl.cond = C_NEVER;
      end
      5'd18: begin
        ctrl.op = OP_EMIT;  ctrl.src = SRC_DIGIT;  ctrl.cond = C_MORE;
        ctrl.target = ST_DIGITS;
      end
      default: begin
        ctrl.cond = C_ALWAYS;  ctrl.target = ST_WAIT;
      end
    endcase
  end

endmodule

FILE: src/fdi_dpath.sv
// Datapath of the conversion core: operand registers, digit register,
// double-dabble unit, character counter and the output register.
// Depends on fdi_pkg; driven by control words from the sequencer.
module fdi_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  fdi_pkg::ctrl_t                ctrl,
  input  logic                          exec,
  input  logic                          load_in,
  input  logic [fdi_pkg::FUNC_W-1:0]    func_in,
  input  logic [fdi_pkg::VALUE_W-1:0]   value_in,
  output fdi_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fdi_pkg::CHAR_W-1:0]    char_out,
  output logic                          last,
  output logic [fdi_pkg::COUNT_W-1:0]   char_count
);
  import fdi_pkg::*;

  logic [FUNC_W-1:0]   func;
  logic [VALUE_W-1:0]  value;
  logic [VALUE_W-1:0]  bin;
  logic [DIG_W-1:0]    dig;
  logic [COUNT_W-1:0]  ndig;
  logic [CNT_W-1:0]    cnt;
  logic [COUNT_W-1:0]  count;
  logic                neg;

  logic [DIG_W-1:0]    dab;
  logic [DIG_W-1:0]    oct_dig;
  logic [VALUE_W:0]    oct_src;
  logic [VALUE_W-1:0]  mag;
  logic [3:0]          top;
  logic                emit;
  logic                emit_last;
  logic [CHAR_W-1:0]   emit_char;

  assign top = dig[DIG_W-1 -: 4];
  assign mag = (func == LTR_D && value[VALUE_W-1]) ? (~value + 32'd1) : value;

  // Flags for conditional jumps
  always_comb begin
    status.f_dec  = (func == LTR_D) || (func == LTR_U);
    status.f_oct  = (func == LTR_O);
    status.f_hex  = (func == LTR_X);
    status.f_chr  = (func == LTR_C);
    status.f_pct  = (func == CH_PCT);
    status.cnt_nz = (cnt != '0);
    status.leadz  = (top == 4'd0) && (ndig > 4'd1);
    status.neg    = neg;
    status.more   = (ndig > 4'd1);
  end

  // Add three to every BCD digit above four, then shift in the next bit
  always_comb begin
    dab = dig;
    for (int i = 1; i < NDIG; i++) begin
      if (dig[i*4 +: 4] > 4'd4) begin
        dab[i*4 +: 4] = dig[i*4 +: 4] + 4'd3;
      end
    end
    dab = {dab[DIG_W-2:4], bin[VALUE_W-1], 4'd0};
  end

  // Spread octal digits into one nibble each, most significant first
  always_comb begin
    oct_src = {1'b0, value};
    oct_dig = '0;
    for (int k = 0; k < NDIG; k++) begin
      oct_dig[k*4 +: 4] = {1'b0, oct_src[k*3 +: 3]};
    end
  end

  // Select the character and last flag of an emit step
  always_comb begin
    emit_last = ctrl.last;
    case (ctrl.src)
      SRC_DIGIT: begin
        emit_char = digit_char(top);
        emit_last = (ndig == 4'd1);
      end
      SRC_MINUS: emit_char = CH_MINUS;
      SRC_PCT:   emit_char = CH_PCT;
      SRC_FUNC:  emit_char = func;
      SRC_BYTE:  emit_char = value[CHAR_W-1:0];
      default:   emit_char = CH_PCT;
    endcase
  end

  assign emit = exec && (ctrl.op == OP_EMIT);

  // Operand and digit registers
  always_ff @(posedge clk) begin
    if (load_in) begin
      func  <= func_in;
      value <= value_in;
    end
    if (exec) begin
      case (ctrl.op)
        OP_INIT_DEC: begin
          bin <= mag;
          dig <= '0;
          cnt <= '1;
          neg <= (func == LTR_D) && value[VALUE_W-1];
        end
        OP_DABBLE: begin
          dig <= dab;
          bin <= {bin[VALUE_W-2:0], 1'b0};
          cnt <= cnt - 5'd1;
        end
        OP_LOAD_DEC: begin
          dig  <= {dig[DIG_W-1:4], 4'd0};
          ndig <= 4'd10;
        end
        OP_INIT_OCT: begin
          dig  <= oct_dig;
          ndig <= 4'd11;
          neg  <= 1'b0;
        end
        OP_INIT_HEX: begin
          dig  <= {value, 12'd0};
          ndig <= 4'd8;
          neg  <= 1'b0;
        end
        OP_SKIP: begin
          if (status.leadz) begin
            dig  <= {dig[DIG_W-5:0], 4'd0};
            ndig <= ndig - 4'd1;
          end
        end
        OP_EMIT: begin
          if (ctrl.src == SRC_DIGIT) begin
            dig  <= {dig[DIG_W-5:0], 4'd0};
            ndig <= ndig - 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Count characters of the current request
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load_in) begin
      count <= '0;
    end else if (emit) begin
      count <= count + 4'd1;
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_out   <= emit_char;
      last       <= emit_last;
      char_count <= emit_last ? (count + 4'd1) : 4'd0;
    end
  end

endmodule

FILE: src/format_directive_integer_to_ascii_core.sv
// Top level of the printf integer-to-ASCII conversion core.
// Step counter and jump logic; instantiates fdi_urom and fdi_dpath.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata: func[7:0], value[39:8]
// m_*      out  m_tvalid/m_tready   m_tdata: char_out[7:0], char_count[11:8]; m_tlast
//
// One request at a time. Decimal takes 32 double-dabble steps of the shared
// digit register, then leading-zero skips and characters (ten steps together).
// An emit step holds while the output register is full and not taken.
// Reset returns the step counter to the wait step and empties the output.
module format_directive_integer_to_ascii_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fdi_pkg::S_DATA_W-1:0]   s_tdata,   // func[7:0], value[39:8]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fdi_pkg::M_DATA_W-1:0]   m_tdata,   // char_out[7:0], char_count[11:8], zero[15:12]
  output logic                           m_tlast
);
  import fdi_pkg::*;

  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  ctrl_t              ctrl;
  status_t            status;
  logic               exec;
  logic               taken;
  logic               load_in;
  logic [CHAR_W-1:0]  char_out;
  logic [COUNT_W-1:0] char_count;

  fdi_urom u_urom (
    .addr (step),
    .ctrl (ctrl)
  );

  assign s_tready = ctrl.wait_in;
  assign load_in  = s_tvalid && s_tready;

  // Hold an emit step while the output register is occupied
  assign exec = (ctrl.op != OP_EMIT) || !m_tvalid || m_tready;

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      C_NEVER:   taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_NO_IN:   taken = !s_tvalid;
      C_F_DEC:   taken = status.f_dec;
      C_F_OCT:   taken = status.f_oct;
      C_F_HEX:   taken = status.f_hex;
      C_F_CHR:   taken = status.f_chr;
      C_F_PCT:   taken = status.f_pct;
      C_CNT_NZ:  taken = status.cnt_nz;
      C_LEADZ:   taken = status.leadz;
      C_NOT_NEG: taken = !status.neg;
      C_MORE:    taken = status.more;
      default:   taken = 1'b1;
    endcase
  end

  // Advance the step counter
  always_comb begin
    if (!exec) begin
      step_next = step;
    end else if (taken) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  fdi_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .exec       (exec),
    .load_in    (load_in),
    .func_in    (s_tdata[7:0]),
    .value_in   (s_tdata[39:8]),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .char_out   (char_out),
    .last       (m_tlast),
    .char_count (char_count)
  );

  assign m_tdata = {4'd0, char_count, char_out};

endmodule

FILE: tb/fdi_char_checker.sv
// Scoreboard for the printf integer-to-ASCII core: predicts the characters of
// each accepted request and compares them with the output stream.
// Depends on fdi_pkg for the ASCII codes and directive letters.
module fdi_char_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // func[7:0], value[39:8]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // char_out[7:0], char_count[11:8], zero[15:12]
  input  logic        m_tlast,
  output int          mismatch_count,
  output int          pending_count
);
  import fdi_pkg::*;

  localparam logic [31:0] RADIX_DEC = 32'd10;
  localparam logic [31:0] RADIX_OCT = 32'd8;
  localparam logic [31:0] RADIX_HEX = 32'd16;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    logic [3:0] count;
  } char_exp_t;

  char_exp_t expected_chars[$];
  char_exp_t head;
  int        errors = 0;
  int        pending = 0;

  assign mismatch_count = errors;
  assign pending_count  = pending;

  // Expand one directive into the characters it prints
  function automatic void queue_conversion(input logic [7:0] letter, input logic [31:0] arg);
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    logic [31:0] mag;
    logic [31:0] radix;
    logic [31:0] rem;
    char_exp_t   rec;
    radix = 32'd0;
    mag   = arg;
    case (letter)
      LTR_D: begin
        radix = RADIX_DEC;
        if (arg[31]) begin
          text.push_back(CH_MINUS);
          mag = 32'd0 - arg;
        end
      end
      LTR_U: radix = RADIX_DEC;
      LTR_O: radix = RADIX_OCT;
      LTR_X: radix = RADIX_HEX;
      LTR_C: text.push_back(arg[7:0]);
      CH_PCT: text.push_back(CH_PCT);
      default: begin
        text.push_back(CH_PCT);
        text.push_back(letter);
      end
    endcase
    // Peel digits off the low end, most significant ends up in front
    if (radix != 32'd0) begin
      do begin
        rem = mag % radix;
        if (rem < 32'd10) begin
          digits.push_front(CH_ZERO + {4'd0, rem[3:0]});
        end else begin
          digits.push_front(CH_A + {4'd0, rem[3:0]} - 8'd10);
        end
        mag = mag / radix;
      end while (mag != 32'd0);
      foreach (digits[i]) text.push_back(digits[i]);
    end
    foreach (text[i]) begin
      rec.ch      = text[i];
      rec.is_last = (i == text.size() - 1);
      rec.count   = rec.is_last ? 4'(text.size()) : 4'd0;
      expected_chars.push_back(rec);
    end
  endfunction

  // Check outgoing characters first, then record the new request
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character 0x%02h with no request pending", m_tdata[7:0]);
          errors = errors + 1;
        end else begin
          head = expected_chars.pop_front();
          if (m_tdata[7:0] !== head.ch) begin
            $error("char_out: expected 0x%02h, got 0x%02h", head.ch, m_tdata[7:0]);
            errors = errors + 1;
          end
          if (m_tlast !== head.is_last) begin
            $error("last: expected %0d, got %0d", head.is_last, m_tlast);
            errors = errors + 1;
          end
          if (m_tdata[11:8] !== head.count) begin
            $error("char_count: expected %0d, got %0d", head.count, m_tdata[11:8]);
            errors = errors + 1;
          end
          if (m_tdata[15:12] !== 4'd0) begin
            $error("tdata padding: expected 0, got 0x%01h", m_tdata[15:12]);
            errors = errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        queue_conversion(s_tdata[7:0], s_tdata[39:8]);
      end
      pending = expected_chars.size();
    end
  end

endmodule

FILE: tb/tb_format_directive_integer_to_ascii_core.sv
// Testbench top for the printf integer-to-ASCII core: clock, reset, request
// stimulus, output back-pressure and the final verdict.
// Depends on fdi_pkg, the core and fdi_char_checker.
module tb_format_directive_integer_to_ascii_core;
  import fdi_pkg::*;

  // Letters outside the supported set
  localparam logic [7:0] LTR_S       = 8'h73;
  localparam logic [7:0] LTR_UPPER_D = 8'h44;
  localparam logic [7:0] LTR_NUL     = 8'h00;
  localparam logic [7:0] LTR_TOP     = 8'hFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  int          mismatch_count;
  int          pending_count;
  bit          gaps_on = 1'b1;
  bit          hold_output = 1'b0;

  format_directive_integer_to_ascii_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  fdi_char_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the core hangs
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      m_tready <= !gaps_on || ($urandom_range(99) >= 12);
    end
  end

  // Offer one request and hold it until accepted, then maybe idle
  task automatic send_request(input logic [7:0] letter, input logic [31:0] arg);
    s_tvalid <= 1'b1;
    s_tdata  <= {arg, letter};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 60)) @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  endtask

  // Stop sending until every predicted character has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 10))
      0, 1:    return LTR_D;
      2:       return LTR_U;
      3, 4:    return LTR_O;
      5, 6:    return LTR_X;
      7:       return LTR_C;
      8:       return CH_PCT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mix small, negative, power-of-two and fully random arguments
  function automatic logic [31:0] pick_argument();
    case ($urandom_range(0, 5))
      0:       return 32'($urandom_range(0, 20));
      1:       return 32'd0 - 32'($urandom_range(1, 20));
      2:       return (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, every letter, sign edge cases
    send_request(LTR_D, 32'd0);
    send_request(LTR_D, 32'd1);
    send_request(LTR_D, 32'hFFFF_FFFF);
    send_request(LTR_D, 32'h7FFF_FFFF);
    send_request(LTR_D, 32'h8000_0000);
    send_request(LTR_D, 32'd10);
    send_request(LTR_U, 32'd0);
    send_request(LTR_U, 32'hFFFF_FFFF);
    send_request(LTR_U, 32'd1000000000);
    send_request(LTR_O, 32'd0);
    send_request(LTR_O, 32'hFFFF_FFFF);
    send_request(LTR_O, 32'd8);
    send_request(LTR_X, 32'd0);
    send_request(LTR_X, 32'hFFFF_FFFF);
    send_request(LTR_X, 32'hDEAD_BEEF);
    send_request(LTR_C, 32'hABCD_EF41);
    send_request(LTR_C, 32'h0000_00FF);
    send_request(LTR_C, 32'd0);
    send_request(CH_PCT, $urandom());
    send_request(LTR_S, 32'h1234_5678);
    send_request(LTR_NUL, 32'd0);
    send_request(LTR_TOP, 32'hFFFF_FFFF);
    send_request(LTR_UPPER_D, 32'd42);

    // Random traffic with gaps on both sides
    repeat (120) send_request(pick_letter(), pick_argument());

    // Hold the output off and keep offering so the core backs up
    hold_output = 1'b1;
    repeat (40) send_request(pick_letter(), pick_argument());
    wait_drained();

    // Back-to-back stretch with no idling on either side
    gaps_on = 1'b0;
    repeat (80) send_request(pick_letter(), pick_argument());
    gaps_on = 1'b1;
    repeat (107) send_request(pick_letter(), pick_argument());

    // Drain, then give stray characters a chance to show up
    wait_drained();
    repeat (100) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
